[sv/dcm2q_pkg.sv]
package dcm2q_pkg;

  localparam int MAG_W       = 33;
  localparam int LANES       = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] PIV_S = 2'd0;
  localparam logic [1:0] PIV_X = 2'd1;
  localparam logic [1:0] PIV_Y = 2'd2;
  localparam logic [1:0] PIV_Z = 2'd3;

  // One classified matrix: pivot, squared-term magnitude and the three
  // off-diagonal numerators of the non-pivot components, in ascending order.
  typedef struct packed {
    logic [1:0]                  pivot;
    logic                        degen;
    logic [MAG_W-1:0]            s_mag;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } dq_item_t;

endpackage

[sv/dcm2q_if.sv]
interface dcm2q_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface dcm2q_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] q_scalar;
  logic signed [31:0] q_x;
  logic signed [31:0] q_y;
  logic signed [31:0] q_z;
  logic               degenerate;

  modport source (output valid, q_scalar, q_x, q_y, q_z, degenerate, input ready);
  modport sink (input valid, q_scalar, q_x, q_y, q_z, degenerate, output ready);
endinterface

[sv/dcm_to_quaternion_core.sv]
// The square root yields one root bit per stage and the divider one quotient bit
//   per stage, both most significant first.
// One matrix per cycle unless quat stalls; the root and divider are fully pipelined.
// A four-entry queue between the classify stage and the arithmetic pipeline
//   lets each side stall on its own.
// Reset (rst, synchronous): clears all valid flags and queue pointers.
module dcm_to_quaternion_core #(
  parameter int FRAC_BITS = 30
) (
  input  logic          clk,
  input  logic          rst,
  dcm2q_in_if.sink      mat,
  dcm2q_out_if.source   quat
);
  import dcm2q_pkg::*;

  logic     f_valid, f_ready, q_valid, q_ready;
  dq_item_t f_item, q_item;

  dcm2q_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .mat        (mat),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  dcm2q_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  dcm2q_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .quat       (quat)
  );

endmodule

[sv/dcm2q_front.sv]
module dcm2q_front #(
  parameter int FRAC_BITS = 30
) (
  input  logic                clk,
  input  logic                rst,
  dcm2q_in_if.sink            mat,
  output logic                item_valid,
  input  logic                item_ready,
  output dcm2q_pkg::dq_item_t item
);
  import dcm2q_pkg::*;

  localparam logic signed [34:0] ONE = 35'sd1 <<< FRAC_BITS;

  logic               adv;
  logic signed [34:0] e00, e11, e22;
  logic signed [34:0] s0, s1, s2, s3, s_max;
  logic [1:0]         piv;
  logic signed [32:0] dp, dq, dr, da, db, dc;
  logic signed [32:0] d0, d1, d2;
  dq_item_t           item_next;

  assign adv       = !item_valid || item_ready;
  assign mat.ready = adv;

  always_comb begin
    e00 = 35'(mat.m00);
    e11 = 35'(mat.m11);
    e22 = 35'(mat.m22);
    s0  = ONE + e00 + e11 + e22;
    s1  = ONE + e00 - e11 - e22;
    s2  = ONE - e00 + e11 - e22;
    s3  = ONE - e00 - e11 + e22;
    // first of the largest wins on a tie
    piv   = PIV_S;
    s_max = s0;
    if (s1 > s_max) begin
      piv   = PIV_X;
      s_max = s1;
    end
    if (s2 > s_max) begin
      piv   = PIV_Y;
      s_max = s2;
    end
    if (s3 > s_max) begin
      piv   = PIV_Z;
      s_max = s3;
    end
    dp = 33'(mat.m12) - 33'(mat.m21);
    dq = 33'(mat.m20) - 33'(mat.m02);
    dr = 33'(mat.m01) - 33'(mat.m10);
    da = 33'(mat.m01) + 33'(mat.m10);
    db = 33'(mat.m20) + 33'(mat.m02);
    dc = 33'(mat.m12) + 33'(mat.m21);
    case (piv)
      PIV_S: begin
        d0 = dp; d1 = dq; d2 = dr;
      end
      PIV_X: begin
        d0 = dp; d1 = da; d2 = db;
      end
      PIV_Y: begin
        d0 = dq; d1 = da; d2 = dc;
      end
      default: begin
        d0 = dr; d1 = db; d2 = dc;
      end
    endcase
    item_next.pivot  = piv;
    item_next.degen  = (s_max <= 35'sd0);
    item_next.s_mag  = item_next.degen ? '0 : s_max[MAG_W-1:0];
    item_next.neg    = {d2[32], d1[32], d0[32]};
    item_next.mag[0] = d0[32] ? 33'(-d0) : 33'(d0);
    item_next.mag[1] = d1[32] ? 33'(-d1) : 33'(d1);
    item_next.mag[2] = d2[32] ? 33'(-d2) : 33'(d2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (adv) begin
      item_valid <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mat.valid) begin
      item <= item_next;
    end
  end

endmodule

[sv/dcm2q_queue.sv]
module dcm2q_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  dcm2q_pkg::dq_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output dcm2q_pkg::dq_item_t pop_item
);
  import dcm2q_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  dq_item_t       slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;
  logic           push, pop;

  assign push_ready = (count != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[sv/dcm2q_back.sv]
module dcm2q_back #(
  parameter int FRAC_BITS = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  dcm2q_pkg::dq_item_t item,
  dcm2q_out_if.source         quat
);
  import dcm2q_pkg::*;

  localparam int RB = (FRAC_BITS + 32) / 2;   // root bits
  localparam int RW = 2 * RB;                 // radicand bits
  localparam int DW = RB + 2;                 // divisor bits
  localparam int CW = RB + 34;                // remainder bits
  localparam int QB = 32;                     // quotient bits

  logic adv;

  // square root stages
  logic [RB:0]    sq_v;
  dq_item_t       sq_item [RB+1];
  logic [RW-1:0]  sq_rem  [RB+1];
  logic [RB-1:0]  sq_root [RB+1];

  // divide stages
  logic [QB:0]    dv_v;
  dq_item_t       dv_item [QB+1];
  logic [DW-1:0]  dv_den  [QB+1];
  logic [CW-1:0]  dv_rem  [QB+1][LANES];
  logic [QB-1:0]  dv_q    [QB+1][LANES];
  logic           dv_ovf  [QB+1][LANES];

  logic              out_v;
  logic signed [31:0] lane_val [LANES];
  logic signed [31:0] piv_val;

  assign adv        = !out_v || quat.ready;
  assign item_ready = adv;
  assign quat.valid = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v  <= '0;
      dv_v  <= '0;
      out_v <= 1'b0;
    end else if (adv) begin
      sq_v  <= {sq_v[RB-1:0], item_valid};
      dv_v  <= {dv_v[QB-1:0], sq_v[RB]};
      out_v <= dv_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_item[0] <= item;
      sq_rem[0]  <= RW'(item.s_mag) << (FRAC_BITS - 2);
      sq_root[0] <= '0;
    end
  end

  // one root bit per stage, most significant first
  for (genvar j = 1; j <= RB; j++) begin : g_sqrt
    localparam int I = RB - j;
    logic [RW:0]   trial;
    logic          ge;
    logic [RB-1:0] root_next;
    always_comb begin
      trial     = ((RW+1)'(sq_root[j-1]) << (I + 1)) | ((RW+1)'(1) << (2 * I));
      ge        = ({1'b0, sq_rem[j-1]} >= trial);
      root_next = sq_root[j-1];
      root_next[I] = ge;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_item[j] <= sq_item[j-1];
        sq_rem[j]  <= ge ? sq_rem[j-1] - trial[RW-1:0] : sq_rem[j-1];
        sq_root[j] <= root_next;
      end
    end
  end

  // divider setup: quotient beyond 32 bits flags saturation up front
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_item[0] <= sq_item[RB];
      dv_den[0]  <= {sq_root[RB], 2'b00};
      for (int l = 0; l < LANES; l++) begin
        dv_rem[0][l] <= CW'(sq_item[RB].mag[l]) << FRAC_BITS;
        dv_q[0][l]   <= '0;
        dv_ovf[0][l] <= ((CW'(sq_item[RB].mag[l]) << FRAC_BITS) >=
                         (CW'({sq_root[RB], 2'b00}) << QB));
      end
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int I = QB - j;
    logic [CW-1:0] shifted;
    assign shifted = CW'(dv_den[j-1]) << I;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_item[j] <= dv_item[j-1];
        dv_den[j]  <= dv_den[j-1];
        for (int l = 0; l < LANES; l++) begin
          dv_ovf[j][l] <= dv_ovf[j-1][l];
          if (dv_rem[j-1][l] >= shifted) begin
            dv_rem[j][l]    <= dv_rem[j-1][l] - shifted;
            dv_q[j][l]      <= dv_q[j-1][l] | (QB'(1) << I);
          end else begin
            dv_rem[j][l]    <= dv_rem[j-1][l];
            dv_q[j][l]      <= dv_q[j-1][l];
          end
        end
      end
    end
  end

  // sign and saturate each lane; the root never exceeds 31 bits
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dv_item[QB].neg[l]) begin
        lane_val[l] = (dv_ovf[QB][l] || dv_q[QB][l][31]) ? 32'sh80000000
                                                         : -$signed(dv_q[QB][l]);
      end else begin
        lane_val[l] = (dv_ovf[QB][l] || dv_q[QB][l][31]) ? 32'sh7FFFFFFF
                                                         : $signed(dv_q[QB][l]);
      end
    end
    piv_val = $signed(32'(dv_den[QB][DW-1:2]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_item[QB].degen) begin
        quat.q_scalar   <= '0;
        quat.q_x        <= '0;
        quat.q_y        <= '0;
        quat.q_z        <= '0;
        quat.degenerate <= 1'b1;
      end else begin
        quat.degenerate <= 1'b0;
        case (dv_item[QB].pivot)
          PIV_S: begin
            quat.q_scalar <= piv_val;     quat.q_x <= lane_val[0];
            quat.q_y      <= lane_val[1]; quat.q_z <= lane_val[2];
          end
          PIV_X: begin
            quat.q_scalar <= lane_val[0]; quat.q_x <= piv_val;
            quat.q_y      <= lane_val[1]; quat.q_z <= lane_val[2];
          end
          PIV_Y: begin
            quat.q_scalar <= lane_val[0]; quat.q_x <= lane_val[1];
            quat.q_y      <= piv_val;     quat.q_z <= lane_val[2];
          end
          default: begin
            quat.q_scalar <= lane_val[0]; quat.q_x <= lane_val[1];
            quat.q_y      <= lane_val[2]; quat.q_z <= piv_val;
          end
        endcase
      end
    end
  end

endmodule

[tb/dcm_to_quaternion_core_tb.sv]
module dcm_to_quaternion_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcm2q_pkg::*;

  localparam int FRAC    = 30;
  localparam int LATENCY = (FRAC + 32) / 2 + 36;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] qs;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic               degen;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors = 0;
  int   stall_mode = 0;
  quat_t quat_expected[$];

  dcm2q_in_if  mat();
  dcm2q_out_if quat();

  dcm_to_quaternion_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .mat(mat.sink), .quat(quat.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    mat.valid = 1'b0;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
    quat.ready = 1'b0;
  end

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] scaled_quotient(longint num, logic [63:0] den);
    logic [63:0] mag, qv;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    qv = (mag << FRAC) / den;
    if (num < 0) return (qv >= 64'd2147483648) ? 32'(SMIN) : 32'(-longint'(qv));
    return (qv > 64'(SMAX)) ? 32'(SMAX) : 32'(qv);
  endfunction

  function automatic quat_t predict_quat(logic signed [31:0] m [9]);
    longint e [9];
    longint sq [4];
    longint dn [4][4];
    longint pv;
    logic [63:0] piv;
    logic signed [31:0] q [4];
    int k;
    quat_t r;
    for (int i = 0; i < 9; i++) e[i] = m[i];
    pv = longint'(1) << FRAC;
    sq[PIV_S] = pv + e[0] + e[4] + e[8];
    sq[PIV_X] = pv + e[0] - e[4] - e[8];
    sq[PIV_Y] = pv - e[0] + e[4] - e[8];
    sq[PIV_Z] = pv - e[0] - e[4] + e[8];
    k = 0;
    for (int i = 1; i < 4; i++) if (sq[i] > sq[k]) k = i;
    r = '0;
    if (sq[k] <= 0) begin
      r.degen = 1'b1;
      return r;
    end
    dn[PIV_S][1] = e[5] - e[7]; dn[PIV_S][2] = e[6] - e[2]; dn[PIV_S][3] = e[1] - e[3];
    dn[PIV_X][0] = e[5] - e[7]; dn[PIV_X][2] = e[1] + e[3]; dn[PIV_X][3] = e[6] + e[2];
    dn[PIV_Y][0] = e[6] - e[2]; dn[PIV_Y][1] = e[1] + e[3]; dn[PIV_Y][3] = e[5] + e[7];
    dn[PIV_Z][0] = e[1] - e[3]; dn[PIV_Z][1] = e[6] + e[2]; dn[PIV_Z][2] = e[5] + e[7];
    piv = root64(64'(sq[k]) << (FRAC - 2));
    if (piv > 64'(SMAX)) piv = 64'(SMAX);
    for (int i = 0; i < 4; i++)
      q[i] = (i == k) ? 32'(piv) : scaled_quotient(dn[k][i], piv << 2);
    r.qs = q[0]; r.qx = q[1]; r.qy = q[2]; r.qz = q[3];
    return r;
  endfunction

  task automatic send_matrix(logic signed [31:0] m [9]);
    mat.valid <= 1'b1;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22}
      <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    do @(posedge clk); while (!mat.ready);
    quat_expected.push_back(predict_quat(m));
  endtask

  task automatic idle_sender(int n);
    mat.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Receiver stall pattern; mode changes per test.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    case (stall_mode)
      0: quat.ready <= 1'b1;
      1: quat.ready <= ($urandom_range(3, 0) != 0);
      2: quat.ready <= (cycles % 16) < 5;
      default: quat.ready <= ($urandom_range(1, 0) == 0);
    endcase
  end

  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && quat.valid && quat.ready) begin
      got = '{quat.q_scalar, quat.q_x, quat.q_y, quat.q_z, quat.degenerate};
      if (quat_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = quat_expected.pop_front();
        if (got.qs !== want.qs) begin
          $display("%0t: q_scalar expected %h actual %h", $time, want.qs, got.qs); errors++;
        end
        if (got.qx !== want.qx) begin
          $display("%0t: q_x expected %h actual %h", $time, want.qx, got.qx); errors++;
        end
        if (got.qy !== want.qy) begin
          $display("%0t: q_y expected %h actual %h", $time, want.qy, got.qy); errors++;
        end
        if (got.qz !== want.qz) begin
          $display("%0t: q_z expected %h actual %h", $time, want.qz, got.qz); errors++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degen, got.degen);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] near_unit();
    // values within [-1, 1] in Q2.30
    return 32'($signed($urandom_range(32'h8000_0000, 0)) - 32'sh4000_0000);
  endfunction

  task automatic test_directed();
    logic signed [31:0] m [9];
    logic signed [31:0] one;
    one = 32'sh4000_0000;
    // identity, each axis pivot, and a four-way tie at zero off-diagonals
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};        send_matrix(m);
    m = '{one, 0, 0, 0, -one, 0, 0, 0, -one};      send_matrix(m);
    m = '{-one, 0, 0, 0, one, 0, 0, 0, -one};      send_matrix(m);
    m = '{-one, 0, 0, 0, -one, 0, 0, 0, one};      send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};              send_matrix(m);
    // negative diagonals: the scalar squared term is non-positive, the others positive
    m = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};     send_matrix(m);
    m = '{32'sh8000_0000, 1, 2, 3, 32'sh8000_0000, 4, 5, 6, 32'sh8000_0000}; send_matrix(m);
    // extreme off-diagonals: largest numerator magnitude, positive then negative
    m = '{-one + 1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0,
          32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 0};  send_matrix(m);
    m = '{-one + 1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0,
          32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0};  send_matrix(m);
    // largest positive diagonal: the largest squared term
    m = '{32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff}; send_matrix(m);
    m = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
          32'sh8000_0000};                             send_matrix(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};     send_matrix(m);
    // x and y tie
    m = '{0, 5, -5, 7, 0, -7, 9, 9, -one};         send_matrix(m);
    idle_sender(1);
  endtask

  task automatic test_random(int n, int mode);
    logic signed [31:0] m [9];
    int burst;
    stall_mode = mode;
    while (n > 0) begin
      burst = $urandom_range(40, 1);
      for (int b = 0; b < burst && n > 0; b++, n--) begin
        for (int i = 0; i < 9; i++) begin
          case ($urandom_range(9, 0))
            0, 1:    m[i] = $urandom();
            2:       m[i] = ($urandom_range(1, 0) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
            3:       m[i] = $signed($urandom_range(64, 0)) - 32;
            default: m[i] = near_unit();
          endcase
        end
        send_matrix(m);
      end
      if ($urandom_range(3, 0) != 0) idle_sender($urandom_range(6, 1));
    end
    idle_sender(1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500, 0);
    test_random(400, 1);
    test_random(300, 2);
    test_random(300, 3);
    stall_mode = 0;
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
